// ===== src/alpha_beta_target_tracker_2d_unit_assert.svh =====
// assertion macros for the alpha-beta target tracker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ALPHA_BETA_TARGET_TRACKER_2D_UNIT_ASSERT_SVH
`define ALPHA_BETA_TARGET_TRACKER_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define ABTT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abtt assertion failed");

// next-cycle implication
`define ABTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abtt assertion failed");

`endif

// ===== src/abtt_pkg.sv =====
// package for the alpha-beta target tracker
// widths, fixed-point constants, register indexes and the config struct
`timescale 1ns / 1ps

package abtt_pkg;

  localparam int POS_FRAC_BITS  = 4;
  localparam int GAIN_FRAC_BITS = 15;

  localparam int COORD_W = 16;
  localparam int GAIN_W  = 16;
  localparam int POS_W   = COORD_W + POS_FRAC_BITS;
  localparam int VEL_W   = POS_W + 1;
  localparam int ACC_W   = VEL_W + 5;
  localparam int PROD_W  = GAIN_W + 1 + ACC_W;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam int POS_HALF = (POS_FRAC_BITS > 0) ? (1 << (POS_FRAC_BITS - 1)) : 0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SMOOTHING_ON   = 3'd0,
    CFG_POSITION_GAIN  = 3'd1,
    CFG_VELOCITY_GAIN  = 3'd2,
    CFG_VELOCITY_LIMIT = 3'd3,
    CFG_IMAGE_WIDTH    = 3'd4,
    CFG_IMAGE_HEIGHT   = 3'd5,
    CFG_NO_TARGET_CODE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                    bypass;
    logic [COORD_W-1:0]      no_target_code;
    logic [GAIN_W-1:0]       alpha;
    logic [GAIN_W-1:0]       beta;
    logic signed [VEL_W-1:0] vmax;
    logic [COORD_W-1:0]      lim_x;
    logic [COORD_W-1:0]      lim_y;
  } cfg_t;

endpackage

// ===== src/abtt_cfg_regs.sv =====
// configuration registers of the target tracker
// holds the seven registers and derives gains, limits and the bypass flag
`timescale 1ns / 1ps

module abtt_cfg_regs import abtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  logic               smoothing_on_q;
  logic [GAIN_W-1:0]  position_gain_q;
  logic [GAIN_W-1:0]  velocity_gain_q;
  logic [CFG_W-1:0]   velocity_limit_q;
  logic [COORD_W-1:0] image_width_q;
  logic [COORD_W-1:0] image_height_q;
  logic [COORD_W-1:0] no_target_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_on_q   <= 1'b1;
      position_gain_q  <= GAIN_W'(16384);
      velocity_gain_q  <= GAIN_W'(4096);
      velocity_limit_q <= CFG_W'(64);
      image_width_q    <= COORD_W'(640);
      image_height_q   <= COORD_W'(480);
      no_target_code_q <= COORD_W'(65535);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SMOOTHING_ON:   smoothing_on_q   <= cfg_data_i[0];
        CFG_POSITION_GAIN:  position_gain_q  <= cfg_data_i;
        CFG_VELOCITY_GAIN:  velocity_gain_q  <= cfg_data_i;
        CFG_VELOCITY_LIMIT: velocity_limit_q <= cfg_data_i;
        CFG_IMAGE_WIDTH:    image_width_q    <= cfg_data_i;
        CFG_IMAGE_HEIGHT:   image_height_q   <= cfg_data_i;
        CFG_NO_TARGET_CODE: no_target_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.bypass = !smoothing_on_q || (image_width_q == '0) || (image_height_q == '0);
    cfg_o.no_target_code = no_target_code_q;
    cfg_o.alpha = (position_gain_q > GAIN_ONE) ? GAIN_ONE : position_gain_q;
    cfg_o.beta  = (velocity_gain_q > GAIN_ONE) ? GAIN_ONE : velocity_gain_q;
    cfg_o.vmax  = $signed(VEL_W'(velocity_limit_q) << POS_FRAC_BITS);
    cfg_o.lim_x = image_width_q - COORD_W'(1);
    cfg_o.lim_y = image_height_q - COORD_W'(1);
  end

endmodule

// ===== src/abtt_axis.sv =====
// one axis of the alpha-beta update, combinational
// clamps the measurement, predicts, corrects, limits and rounds; uses abtt_pkg
`timescale 1ns / 1ps

module abtt_axis import abtt_pkg::*; (
  input  logic                    locked_i,
  input  logic [COORD_W-1:0]      meas_i,
  input  logic [COORD_W-1:0]      lim_i,
  input  logic [POS_W-1:0]        pos_i,
  input  logic signed [VEL_W-1:0] vel_i,
  input  logic [GAIN_W-1:0]       alpha_i,
  input  logic [GAIN_W-1:0]       beta_i,
  input  logic signed [VEL_W-1:0] vmax_i,
  output logic [POS_W-1:0]        pos_o,
  output logic signed [VEL_W-1:0] vel_o,
  output logic [COORD_W-1:0]      coord_o
);

  logic [COORD_W-1:0]       meas_c;
  logic [POS_W-1:0]         meas_q;
  logic signed [ACC_W-1:0]  meas_s;
  logic signed [ACC_W-1:0]  lim_s;
  logic signed [ACC_W-1:0]  pred;
  logic signed [ACC_W-1:0]  resid;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic [PROD_W-1:0]        bias_a;
  logic [PROD_W-1:0]        bias_b;
  logic signed [ACC_W-1:0]  corr_a;
  logic signed [ACC_W-1:0]  corr_b;
  logic signed [ACC_W-1:0]  p_raw;
  logic signed [ACC_W-1:0]  v_raw;
  logic signed [ACC_W-1:0]  v_lim;
  logic signed [ACC_W-1:0]  vmax_s;
  logic signed [ACC_W-1:0]  p_c;
  logic signed [ACC_W-1:0]  v_c;
  logic [POS_W-1:0]         rnd;

  always_comb begin
    meas_c = (meas_i > lim_i) ? lim_i : meas_i;
    meas_q = POS_W'(meas_c) << POS_FRAC_BITS;
    meas_s = $signed(ACC_W'(meas_q));
    lim_s  = $signed(ACC_W'(POS_W'(lim_i) << POS_FRAC_BITS));
    vmax_s = ACC_W'(vmax_i);

    pred  = $signed(ACC_W'(pos_i)) + ACC_W'(vel_i);
    resid = meas_s - pred;

    prod_a = $signed({1'b0, alpha_i}) * resid;
    prod_b = $signed({1'b0, beta_i}) * resid;
    // truncate toward zero
    bias_a = prod_a[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC_BITS) - 1) : '0;
    bias_b = prod_b[PROD_W-1] ? PROD_W'((1 << GAIN_FRAC_BITS) - 1) : '0;
    corr_a = $signed(ACC_W'((prod_a + bias_a) >> GAIN_FRAC_BITS));
    corr_b = $signed(ACC_W'((prod_b + bias_b) >> GAIN_FRAC_BITS));

    p_raw = pred + corr_a;
    v_raw = ACC_W'(vel_i) + corr_b;

    if (v_raw > vmax_s) begin
      v_lim = vmax_s;
    end else if (v_raw < -vmax_s) begin
      v_lim = -vmax_s;
    end else begin
      v_lim = v_raw;
    end

    p_c = p_raw;
    v_c = v_lim;
    if (p_raw < 0) begin
      p_c = '0;
      if (v_lim < 0) v_c = '0;
    end else if (p_raw > lim_s) begin
      p_c = lim_s;
      if (v_lim > 0) v_c = '0;
    end

    if (!locked_i) begin
      pos_o = meas_q;
      vel_o = '0;
    end else begin
      pos_o = p_c[POS_W-1:0];
      vel_o = v_c[VEL_W-1:0];
    end

    rnd = pos_o + POS_W'(POS_HALF);
    coord_o = locked_i ? rnd[POS_W-1:POS_FRAC_BITS] : meas_c;
  end

endmodule

// ===== src/alpha_beta_target_tracker_2d_unit.sv =====
// channel  dir  tdata                       tuser
// s_axis   in   meas_x[15:0] meas_y[31:16]  -
// m_axis   out  out_x[15:0]  out_y[31:16]   target_valid[0]
// cfg      in   write enable, 3-bit index, 16-bit data, no read-back
//
// an accepted beat lands in the input register; once it can advance both axis
// updates run and the result and track state are written together
// one beat per cycle while the output is not stalled; the track state loop
// runs from the track registers through the axis multipliers and back
// reset clears the track and loads the register defaults; a stalled output
// holds its beat while one more beat waits in the input register
`timescale 1ns / 1ps

`include "alpha_beta_target_tracker_2d_unit_assert.svh"

module alpha_beta_target_tracker_2d_unit import abtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,   // meas_x, meas_y
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [31:0]          m_axis_tdata,   // out_x, out_y
  output logic [0:0]           m_axis_tuser,   // target_valid
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t cfg;

  logic                    in_valid_q;
  logic [COORD_W-1:0]      mx_q, my_q;
  logic                    out_valid_q;
  logic [COORD_W-1:0]      ox_q, oy_q;
  logic                    tv_q;

  logic                    locked_q;
  logic [POS_W-1:0]        pos_x_q, pos_y_q;
  logic signed [VEL_W-1:0] vel_x_q, vel_y_q;

  logic                    adv;
  logic                    no_tgt;
  logic                    pass;
  logic [POS_W-1:0]        pos_x_d, pos_y_d;
  logic signed [VEL_W-1:0] vel_x_d, vel_y_d;
  logic [COORD_W-1:0]      cx, cy;

  abtt_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  abtt_axis u_axis_x (
    .locked_i (locked_q),
    .meas_i   (mx_q),
    .lim_i    (cfg.lim_x),
    .pos_i    (pos_x_q),
    .vel_i    (vel_x_q),
    .alpha_i  (cfg.alpha),
    .beta_i   (cfg.beta),
    .vmax_i   (cfg.vmax),
    .pos_o    (pos_x_d),
    .vel_o    (vel_x_d),
    .coord_o  (cx)
  );

  abtt_axis u_axis_y (
    .locked_i (locked_q),
    .meas_i   (my_q),
    .lim_i    (cfg.lim_y),
    .pos_i    (pos_y_q),
    .vel_i    (vel_y_q),
    .alpha_i  (cfg.alpha),
    .beta_i   (cfg.beta),
    .vmax_i   (cfg.vmax),
    .pos_o    (pos_y_d),
    .vel_o    (vel_y_d),
    .coord_o  (cy)
  );

  assign adv    = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign no_tgt = (mx_q == cfg.no_target_code) || (my_q == cfg.no_target_code);
  assign pass   = no_tgt || cfg.bypass;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {oy_q, ox_q};
  assign m_axis_tuser  = tv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      locked_q    <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        if (pass) begin
          locked_q <= 1'b0;
          pos_x_q  <= '0;
          pos_y_q  <= '0;
          vel_x_q  <= '0;
          vel_y_q  <= '0;
        end else begin
          locked_q <= 1'b1;
          pos_x_q  <= pos_x_d;
          pos_y_q  <= pos_y_d;
          vel_x_q  <= vel_x_d;
          vel_y_q  <= vel_y_d;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mx_q <= s_axis_tdata[COORD_W-1:0];
      my_q <= s_axis_tdata[2*COORD_W-1:COORD_W];
    end
    if (adv) begin
      ox_q <= pass ? mx_q : cx;
      oy_q <= pass ? my_q : cy;
      tv_q <= !no_tgt;
    end
  end

  `ABTT_ASSERT_NEXT(a_adv_gives_beat, adv, m_axis_tvalid)
  `ABTT_ASSERT_NEXT(a_no_target_flag, adv && no_tgt, !m_axis_tuser[0] && !locked_q)
  `ABTT_ASSERT_IMPL(a_unlocked_clear, !locked_q,
                    vel_x_q == '0 && vel_y_q == '0 && pos_x_q == '0 && pos_y_q == '0)
  `ABTT_ASSERT_IMPL(a_full_stall, in_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready)

endmodule
